FILE: rtl/okvs_rh_pkg.sv
// Shared types and constants for the OKVS row index hash block.
`default_nettype none
package okvs_rh_pkg;

  localparam int SIZE_W     = 32;
  localparam int WORD_W     = 64;
  localparam int LANES      = 3;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = WORD_W / DIV_STEPS;
  localparam int INDEX_BITS_DEF = 32;

  localparam logic [SIZE_W-1:0] COL_COUNT_RESET = 32'd1024;

  typedef struct packed {
    logic [63:0] hash_low;
    logic [63:0] hash_high;
  } in_t;

  typedef struct packed {
    logic [31:0] index_a;
    logic [31:0] index_b;
    logic [31:0] index_c;
  } out_t;

  // Per-lane divisor (size, size - 1, size - 2) and "divisor not positive" flags.
  typedef struct packed {
    logic [LANES-1:0][SIZE_W-1:0] modulus;
    logic [LANES-1:0]             zero;
  } moduli_t;

endpackage
`default_nettype wire

FILE: rtl/okvs_rh_rem_stage.sv
// One pipeline stage of a restoring 64-by-32 remainder unit.
`default_nettype none
module okvs_rh_rem_stage
  import okvs_rh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SIZE_W-1:0] modulus,
  input  wire logic [SIZE_W-1:0] rem_i,
  input  wire logic [WORD_W-1:0] dvd_i,
  output logic      [SIZE_W-1:0] rem_o,
  output logic      [WORD_W-1:0] dvd_o
);

  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvd_r, dvd_nxt;

  // Shift in the dividend MSB, subtract the divisor if it fits.
  always_comb begin
    logic [SIZE_W:0]   t;
    logic [SIZE_W-1:0] r;
    logic [WORD_W-1:0] d;
    r = rem_i;
    d = dvd_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, d[WORD_W-1]};
      d = d << 1;
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      r = t[SIZE_W-1:0];
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign rem_o = rem_r;
  assign dvd_o = dvd_r;

endmodule
`default_nettype wire

FILE: rtl/okvs_rh_bump.sv
// Index bump stage: makes the three column indices distinct.
`default_nettype none
module okvs_rh_bump
  import okvs_rh_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [LANES-1:0]  zero,
  input  wire logic [SIZE_W-1:0] rem_a,
  input  wire logic [SIZE_W-1:0] rem_b,
  input  wire logic [SIZE_W-1:0] rem_c,
  output out_t                   result
);

  logic [INDEX_BITS-1:0] a_nxt, b_nxt, c_nxt, lo_nxt, hi_nxt;
  logic [INDEX_BITS-1:0] a_r, b_r, c_r, lo_r, hi_r;
  logic [INDEX_BITS-1:0] c1, c2;

  // First half: mask remainders, order a/b, bump b past a.
  always_comb begin
    logic [INDEX_BITS-1:0] a, b;
    a = zero[0] ? '0 : INDEX_BITS'(rem_a);
    b = zero[1] ? '0 : INDEX_BITS'(rem_b);
    c_nxt = zero[2] ? '0 : INDEX_BITS'(rem_c);
    a_nxt = a;
    if (a <= b) begin
      lo_nxt = a;
      b_nxt  = b + 1'b1;
      hi_nxt = b + 1'b1;
    end else begin
      lo_nxt = b;
      b_nxt  = b;
      hi_nxt = a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // Second half: bump c past the low, then the high index.
  always_comb begin
    c1 = (c_r >= lo_r) ? c_r + 1'b1 : c_r;
    c2 = (c1 >= hi_r) ? c1 + 1'b1 : c1;
    result.index_a = 32'(a_r);
    result.index_b = 32'(b_r);
    result.index_c = 32'(c2);
  end

endmodule
`default_nettype wire

FILE: rtl/okvs_row_index_hash_top.sv
// Top level of the OKVS row index hash: three pipelined remainders plus index bump.
// Path: 16 remainder stages, then the bump register, then the output register.
// Throughput: one transfer per cycle unless stalled; the 64-bit remainder pipeline does 4 bits per stage.
// Stalls: the whole pipeline holds while out_valid is high and out_ready is low.
// Reset: synchronous active-low rst_n clears all valid bits and sets the column count to 1024.
// No clearing pass; the block accepts input in the first cycle after reset.
`default_nettype none
module okvs_row_index_hash_top
  import okvs_rh_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  localparam int NSTAGE = DIV_STAGES + 1;  // remainder stages plus bump stage

  // Divisors are derived once per config transfer, so the remainder
  // stages see a stable value with no extra subtract in their path.
  moduli_t moduli_r, moduli_nxt;

  logic [NSTAGE-1:0] v_r, v_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  out_t              bump_result;
  logic              en;

  logic [LANES-1:0][WORD_W-1:0] word;
  logic [SIZE_W-1:0] rem_w [LANES][DIV_STAGES+1];
  logic [WORD_W-1:0] dvd_w [LANES][DIV_STAGES+1];

  assign cfg_ready = 1'b1;

  always_comb begin
    moduli_nxt = moduli_r;
    if (cfg_valid) begin
      moduli_nxt.modulus[0] = cfg_data;
      moduli_nxt.modulus[1] = cfg_data - 32'd1;
      moduli_nxt.modulus[2] = cfg_data - 32'd2;
      moduli_nxt.zero[0]    = (cfg_data == 32'd0);
      moduli_nxt.zero[1]    = (cfg_data <= 32'd1);
      moduli_nxt.zero[2]    = (cfg_data <= 32'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moduli_r.modulus[0] <= COL_COUNT_RESET;
      moduli_r.modulus[1] <= COL_COUNT_RESET - 32'd1;
      moduli_r.modulus[2] <= COL_COUNT_RESET - 32'd2;
      moduli_r.zero       <= '0;
    end else begin
      moduli_r <= moduli_nxt;
    end
  end

  // Lockstep pipeline: everything advances unless the output is blocked.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      v_nxt         = {v_r[NSTAGE-2:0], in_valid};
      out_valid_nxt = v_r[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Three overlapping words at bit offsets 0, 32 and 64.
  assign word[0] = in_data.hash_low;
  assign word[1] = {in_data.hash_high[31:0], in_data.hash_low[63:32]};
  assign word[2] = in_data.hash_high;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign rem_w[l][0] = '0;
    assign dvd_w[l][0] = word[l];
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      okvs_rh_rem_stage u_stage (
        .clk     (clk),
        .en      (en),
        .modulus (moduli_r.modulus[l]),
        .rem_i   (rem_w[l][s]),
        .dvd_i   (dvd_w[l][s]),
        .rem_o   (rem_w[l][s+1]),
        .dvd_o   (dvd_w[l][s+1])
      );
    end
  end

  okvs_rh_bump #(
    .INDEX_BITS (INDEX_BITS)
  ) u_bump (
    .clk    (clk),
    .en     (en),
    .zero   (moduli_r.zero),
    .rem_a  (rem_w[0][DIV_STAGES]),
    .rem_b  (rem_w[1][DIV_STAGES]),
    .rem_c  (rem_w[2][DIV_STAGES]),
    .result (bump_result)
  );

  // Output register parts the pipeline from the result channel.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= bump_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the OKVS row index hash: 3-column index prediction and check.
`timescale 1ns / 1ps
module testbench;
  import okvs_rh_pkg::*;

  // Both channels move one transfer when valid and ready are high at a rising edge.
  // Stimulus changes at the falling edge. Results are sampled at the rising edge.
  localparam int DRAIN_CYCLES = 40;   // settling time after the last phase, longer than the pipeline depth
  localparam int PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 85;

  // Idle profiles: sender mostly busy with a stalling receiver, then the reverse,
  // then both sides always ready.
  typedef enum int {SLOW_SINK, SLOW_SOURCE, FULL_RATE} idle_profile_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  in_t           pending_hashes[$];
  out_t          expected_columns[$];
  logic [31:0]   column_count = COL_COUNT_RESET;     // mirror of the column count register
  logic          in_fire = 1'b0;                      // input transfer at the last rising edge
  idle_profile_t idle_profile = SLOW_SINK;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   mismatches = 0;
  int unsigned   results_checked = 0;
  int unsigned   size_writes = 0;

  okvs_row_index_hash_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Remainder of one 64-bit hash word by (size - sub); zero when that divisor
  // is not positive. Fits 32 bits since it is below size.
  function automatic logic [31:0] word_remainder(logic [63:0] word, logic [31:0] size,
                                                 int unsigned sub);
    logic [63:0] divisor;
    divisor = 64'(size) - 64'(sub);
    if (64'(size) <= 64'(sub)) return '0;
    return 32'(word % divisor);
  endfunction

  // Column triple for one hash: three overlapping words at bit offsets 0, 32, 64,
  // reduced by size, size-1, size-2, then bumped apart. Bumps wrap in 32 bits.
  function automatic out_t predict_columns(in_t hash, logic [31:0] size);
    logic [63:0] w_mid;
    logic [31:0] col_a, col_b, col_c, lesser, greater;
    out_t        cols;
    w_mid = {hash.hash_high[31:0], hash.hash_low[63:32]};
    col_a = word_remainder(hash.hash_low, size, 0);
    col_b = word_remainder(w_mid, size, 1);
    col_c = word_remainder(hash.hash_high, size, 2);
    lesser  = (col_a < col_b) ? col_a : col_b;
    greater = (col_a < col_b) ? col_b : col_a;
    // second column skips over the first when it lands on or above it
    if (greater == col_b) begin
      col_b   = col_b + 32'd1;
      greater = greater + 32'd1;
    end
    // third column skips the smaller, then the (bumped) larger
    if (col_c >= lesser) col_c = col_c + 32'd1;
    if (col_c >= greater) col_c = col_c + 32'd1;
    cols.index_a = col_a;
    cols.index_b = col_b;
    cols.index_c = col_c;
    return cols;
  endfunction

  // Mix of fully random hashes, hashes built from one repeated 32-bit word
  // (all three words then share a value) and hashes with tiny low and high words.
  function automatic in_t random_hash();
    logic [31:0] rep;
    in_t         hash;
    rep = $urandom;
    case ($urandom_range(3))
      0, 1: begin
        hash.hash_low  = {$urandom, $urandom};
        hash.hash_high = {$urandom, $urandom};
      end
      2: begin
        hash.hash_low  = {rep, rep};
        hash.hash_high = {rep, rep};
      end
      default: begin
        hash.hash_low  = 64'($urandom_range(4095));
        hash.hash_high = 64'($urandom_range(4095));
      end
    endcase
    return hash;
  endfunction

  always_comb begin
    case (idle_profile)
      SLOW_SINK:   begin send_idle_pct = 6;  recv_idle_pct = 88; end
      SLOW_SOURCE: begin send_idle_pct = 88; recv_idle_pct = 6;  end
      default:     begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  end

  // Driver: presents the next pending hash once the current one has transferred,
  // and throttles both in_valid and out_ready per the idle profile.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_hashes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_hashes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every input transfer, tracks size writes, checks results.
  always @(posedge clk) begin
    out_t        want;
    int unsigned errs;
    errs = 0;
    in_fire <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      column_count <= COL_COUNT_RESET;
    end else begin
      if (in_valid && in_ready)
        expected_columns.push_back(predict_columns(in_data, column_count));
      if (cfg_valid && cfg_ready) begin
        column_count <= cfg_data;
        size_writes  <= size_writes + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected result %h with nothing pending", $time, out_data);
          errs = errs + 1;
        end else begin
          want = expected_columns.pop_front();
          results_checked <= results_checked + 1;
          if (out_data.index_a !== want.index_a) begin
            $display("%0t: index_a expected %0d actual %0d", $time, want.index_a,
                     out_data.index_a);
            errs = errs + 1;
          end
          if (out_data.index_b !== want.index_b) begin
            $display("%0t: index_b expected %0d actual %0d", $time, want.index_b,
                     out_data.index_b);
            errs = errs + 1;
          end
          if (out_data.index_c !== want.index_c) begin
            $display("%0t: index_c expected %0d actual %0d", $time, want.index_c,
                     out_data.index_c);
            errs = errs + 1;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
  end

  // Size register write; called only with the pipeline empty.
  task automatic write_column_count(input logic [31:0] size);
    @(negedge clk);
    cfg_data  <= size;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued hash has transferred and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_hashes.size() != 0 || in_valid || expected_columns.size() != 0);
  endtask

  task automatic queue_hash(input logic [63:0] low, input logic [63:0] high);
    in_t hash;
    hash.hash_low  = low;
    hash.hash_high = high;
    pending_hashes.push_back(hash);
  endtask

  initial begin
    logic [31:0] size;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2)      idle_profile = SLOW_SINK;
      else if (phase < 4) idle_profile = SLOW_SOURCE;
      else                idle_profile = FULL_RATE;

      // phase 0 runs on the reset size of 1024
      case (phase)
        1:       size = 32'd3;              // smallest legal size: collisions everywhere
        2:       size = 32'hFFFF_FFFF;      // largest size
        3:       size = 32'd4;
        4:       size = $urandom_range(2000, 5);
        5:       size = 32'hFFFF_FFFE;
        6:       size = $urandom_range(32'hFFFF_FFFF, 3);
        default: size = COL_COUNT_RESET;
      endcase
      if (phase != 0) write_column_count(size);

      if (phase == 0 || phase == 1 || phase == 2) begin
        // field extremes, word-boundary bits, exact multiples of the size
        queue_hash(64'h0, 64'h0);
        queue_hash({64{1'b1}}, {64{1'b1}});
        queue_hash({64{1'b1}}, 64'h0);
        queue_hash(64'h0, {64{1'b1}});
        queue_hash(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_hash(64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000);
        queue_hash(64'h0000_0000_8000_0000, 64'h8000_0000_0000_0001);
        queue_hash(64'h0000_0001_0000_0000, 64'h0000_0000_0000_0001);
        queue_hash(64'(size), 64'(size) - 64'd2);
        queue_hash(64'(size) - 64'd1, 64'(size) - 64'd3);
        queue_hash({32'(size) - 32'd2, 32'h0}, 64'(size) - 64'd3);
        queue_hash({32'(size) - 32'd1, 32'(size) - 32'd1}, {32'h0, 32'h0});
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        pending_hashes.push_back(random_hash());

      wait_drained();
    end

    // let anything stray fall out of the pipeline before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d column triples over %0d size settings (reset value plus %0d writes),",
             results_checked, size_writes + 1, size_writes);
    $display("including sizes 3, 4, 2^32-2 and 2^32-1 under three stall profiles.");
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/okvs_rh_pkg.sv
rtl/okvs_rh_rem_stage.sv
rtl/okvs_rh_bump.sv
rtl/okvs_row_index_hash_top.sv
tb/testbench.sv
